[hw/rtl/pwfr_pkg.sv]
// Shared types and constants of the pulse-width frame receiver.
package pwfr_pkg;

  // Widths fixed by the item and register formats.
  localparam int unsigned TICK_W      = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BIT_POS_W   = 3;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  // Default frame limit handed to the top level.
  localparam int unsigned MAX_FRAME_BYTES_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_START_MIN     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MAX     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MARKER_BYTE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_LENGTH   = 3'd4;

  // Register reset values.
  localparam logic [TICK_W-1:0] START_MIN_RST     = 8'd35;
  localparam logic [TICK_W-1:0] START_MAX_RST     = 8'd45;
  localparam logic [TICK_W-1:0] ONE_THRESHOLD_RST = 8'd8;
  localparam logic [BYTE_W-1:0] MARKER_BYTE_RST   = 8'h55;
  localparam logic [LEN_W-1:0]  LONG_LENGTH_RST   = 5'd9;

  typedef struct packed {
    logic line_level;
  } sample_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_done;
    logic               marker_seen;
  } result_t;

endpackage

[hw/rtl/pwfr_stream_if.sv]
// Valid/ready stream channel carrying one payload per transaction.
interface pwfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/pulse_width_frame_receiver_core.sv]
// Pulse-width frame receiver: decodes line samples into framed bytes.
// Throughput: one sample transaction is accepted in every cycle while the output is drained.
// A completed byte is registered in the output register, or in the skid register if that one is held.
// A two-entry output (output register plus skid register) lets sampling continue while a byte waits.
// Reset (rst, synchronous, active high) restores register defaults and returns the decoder to idle.
module pulse_width_frame_receiver_core #(
  parameter int unsigned MAX_FRAME_BYTES = pwfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pwfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pwfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  pwfr_stream_if.sink                         sample,
  pwfr_stream_if.source                       result
);

  localparam logic [pwfr_pkg::LEN_W-1:0] MAX_LEN = pwfr_pkg::LEN_W'(MAX_FRAME_BYTES);

  // Configuration registers.
  logic [pwfr_pkg::TICK_W-1:0] start_min;
  logic [pwfr_pkg::TICK_W-1:0] start_max;
  logic [pwfr_pkg::TICK_W-1:0] one_threshold;
  logic [pwfr_pkg::BYTE_W-1:0] marker_byte;
  logic [pwfr_pkg::LEN_W-1:0]  long_frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_min         <= pwfr_pkg::START_MIN_RST;
      start_max         <= pwfr_pkg::START_MAX_RST;
      one_threshold     <= pwfr_pkg::ONE_THRESHOLD_RST;
      marker_byte       <= pwfr_pkg::MARKER_BYTE_RST;
      long_frame_length <= pwfr_pkg::LONG_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pwfr_pkg::REG_START_MIN:     start_min         <= cfg_data;
        pwfr_pkg::REG_START_MAX:     start_max         <= cfg_data;
        pwfr_pkg::REG_ONE_THRESHOLD: one_threshold     <= cfg_data;
        pwfr_pkg::REG_MARKER_BYTE:   marker_byte       <= cfg_data;
        pwfr_pkg::REG_LONG_LENGTH:   long_frame_length <= cfg_data[pwfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Decoder state.
  logic                           last_level;
  logic [pwfr_pkg::TICK_W-1:0]    tick_count;
  logic                           receiving;
  logic [pwfr_pkg::BIT_POS_W-1:0] bit_position;
  logic [pwfr_pkg::INDEX_W-1:0]   byte_count;
  logic [pwfr_pkg::BYTE_W-1:0]    shift_byte;
  logic [pwfr_pkg::BYTE_W-1:0]    first_byte;
  logic [pwfr_pkg::LEN_W-1:0]     frame_length;
  logic                           marker_flag;

  // Output register and skid register.
  logic                  out_valid;
  pwfr_pkg::result_t     out_data;
  logic                  skid_valid;
  pwfr_pkg::result_t     skid_data;

  logic sample_fire;
  logic out_fire;

  // The sample side stalls only when both output entries are occupied.
  assign sample.ready = !skid_valid;
  assign sample_fire  = sample.valid && sample.ready;
  assign out_fire     = out_valid && result.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Per-sample decode: all of it is a handful of compares, increments and a shift.
  logic                           level;
  logic                           edge_seen;
  logic                           falling;
  logic [pwfr_pkg::TICK_W-1:0]    tick_inc;
  logic                           bit_value;
  logic [pwfr_pkg::BYTE_W-1:0]    shift_new;
  logic [pwfr_pkg::BIT_POS_W-1:0] bit_position_new;
  logic                           data_edge;
  logic                           byte_complete;
  logic                           start_hit;
  logic [pwfr_pkg::LEN_W-1:0]     done_count;
  logic [pwfr_pkg::BYTE_W-1:0]    first_new;
  logic                           marker_hit;
  logic [pwfr_pkg::LEN_W-1:0]     len_sat;
  logic [pwfr_pkg::LEN_W-1:0]     frame_length_new;
  logic                           frame_end;
  logic                           res_valid;
  pwfr_pkg::result_t              res;

  always_comb begin
    level            = sample.data.line_level;
    edge_seen        = level != last_level;
    falling          = edge_seen && !level;
    tick_inc         = tick_count + pwfr_pkg::TICK_W'(1);
    // The incremented count equals the length, modulo 256, of the high run that a falling edge ends.
    bit_value        = tick_inc >= one_threshold;
    shift_new        = {shift_byte[pwfr_pkg::BYTE_W-2:0], bit_value};
    bit_position_new = bit_position + pwfr_pkg::BIT_POS_W'(1);
    data_edge        = receiving && falling;
    byte_complete    = data_edge && (bit_position_new == '0);
    start_hit        = !receiving && falling && (tick_inc >= start_min) &&
                       (tick_inc <= start_max);

    done_count       = {1'b0, byte_count} + pwfr_pkg::LEN_W'(1);
    first_new        = (byte_count == '0) ? shift_new : first_byte;
    // The marker test uses the frame's first byte: the new byte at index zero, else the latched one.
    marker_hit       = first_new == marker_byte;
    len_sat          = (long_frame_length > MAX_LEN) ? MAX_LEN : long_frame_length;
    frame_length_new = marker_hit ? len_sat : frame_length;
    frame_end        = (done_count >= frame_length_new) || (done_count >= MAX_LEN);

    res_valid        = sample_fire && byte_complete;
    res.byte_value   = shift_new;
    res.byte_index   = byte_count;
    res.frame_done   = frame_end;
    res.marker_seen  = marker_flag || marker_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      tick_count   <= '0;
      receiving    <= 1'b0;
      bit_position <= '0;
      byte_count   <= '0;
      shift_byte   <= '0;
      first_byte   <= '0;
      frame_length <= '0;
      marker_flag  <= 1'b0;
    end else if (sample_fire) begin
      last_level <= level;
      tick_count <= edge_seen ? '0 : tick_inc;
      if (byte_complete) begin
        first_byte   <= first_new;
        frame_length <= frame_length_new;
        marker_flag  <= marker_flag || marker_hit;
        byte_count   <= done_count[pwfr_pkg::INDEX_W-1:0];
        bit_position <= bit_position_new;
        shift_byte   <= '0;
        receiving    <= !frame_end;
      end else if (data_edge) begin
        bit_position <= bit_position_new;
        shift_byte   <= shift_new;
      end else if (start_hit) begin
        receiving    <= 1'b1;
        bit_position <= '0;
        byte_count   <= '0;
        shift_byte   <= '0;
      end
    end
  end

  // Output side. A new byte goes to the output register when it is free or being
  // drained in this cycle, otherwise to the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  // The skid register is only ever filled behind a waiting output register.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register holds a byte while the output register is empty");

  // The marker flag is sticky until reset.
  assert property (@(posedge clk) disable iff (rst) marker_flag |=> marker_flag)
    else $error("marker flag cleared without reset");

  // A frame ends only with a byte that is marked as completing it.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(receiving)) |-> $past(res_valid && res.frame_done))
    else $error("receiver left a frame without emitting its final byte");

  // The latched frame length never exceeds the frame limit.
  assert property (@(posedge clk) disable iff (rst) frame_length <= MAX_LEN)
    else $error("latched frame length above the frame limit");

endmodule

[test/pulse_width_frame_receiver_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the pulse-width frame receiver core with its own decoder model.
module pulse_width_frame_receiver_core_tb;

  // Frame limit of the instance below, which keeps the default.
  localparam int unsigned FRAME_LIMIT    = pwfr_pkg::MAX_FRAME_BYTES_DEF;
  // Generous ceiling on the length of the whole run.
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  // Slack left after the last owed byte has been taken from the core.
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned RANDOM_SAMPLES = 2000;
  // Percentage of cycles in which the result side holds back, and of samples before which the sample side does.
  localparam int unsigned IDLE_PERCENT   = 23;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [pwfr_pkg::CFG_INDEX_W-1:0] cfg_index = pwfr_pkg::REG_START_MIN;
  logic [pwfr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  pwfr_stream_if #(.payload_t(pwfr_pkg::sample_t)) sample_ch ();
  pwfr_stream_if #(.payload_t(pwfr_pkg::result_t)) result_ch ();

  pulse_width_frame_receiver_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  // Copy of the configuration registers as the testbench last wrote them.
  logic [7:0]                 cur_start_min     = pwfr_pkg::START_MIN_RST;
  logic [7:0]                 cur_start_max     = pwfr_pkg::START_MAX_RST;
  logic [7:0]                 cur_one_threshold = pwfr_pkg::ONE_THRESHOLD_RST;
  logic [7:0]                 cur_marker        = pwfr_pkg::MARKER_BYTE_RST;
  logic [pwfr_pkg::LEN_W-1:0] cur_long_len      = pwfr_pkg::LONG_LENGTH_RST;

  // Decoder state of the model, as it stands after reset.
  logic                       prev_level     = 1'b0;
  logic [7:0]                 run_ticks      = '0;
  logic                       framing        = 1'b0;
  logic [2:0]                 bit_slot       = '0;
  logic [3:0]                 bytes_in_frame = '0;
  logic [7:0]                 shift_reg      = '0;
  logic [7:0]                 lead_byte      = '0;
  // Five bits, since a latched length of sixteen must not fold to zero.
  logic [pwfr_pkg::LEN_W-1:0] frame_len      = '0;
  logic                       marker_latched = 1'b0;

  // Bytes the core still owes us, oldest first.
  pwfr_pkg::result_t pending_bytes[$];
  int unsigned       error_count   = 0;
  int unsigned       samples_sent  = 0;
  int unsigned       bytes_checked = 0;
  int unsigned       cycle_count   = 0;

  // When set, neither side inserts idle cycles.
  logic steady = 1'b0;

  // Pulse widths the stimulus uses for the current register setting.
  int unsigned zero_hi  = 3;
  int unsigned one_lo   = 8;
  int unsigned one_hi   = 12;
  int unsigned start_lo = 35;
  int unsigned start_hi = 45;

  // Advances the model by one line sample and reports the byte it completes, if any.
  function automatic void decode_sample(input logic level, output logic emitted,
                                        output pwfr_pkg::result_t produced);
    logic        level_change;
    logic        falling;
    logic        last_byte;
    int unsigned next_count;
    emitted      = 1'b0;
    produced     = '0;
    level_change = (level != prev_level);
    falling      = level_change && !level;
    run_ticks    = run_ticks + 8'd1;
    if (framing) begin
      if (falling) begin
        shift_reg = {shift_reg[6:0], (run_ticks >= cur_one_threshold)};
        bit_slot  = bit_slot + 3'd1;
        if (bit_slot == 3'd0) begin
          if (bytes_in_frame == 4'd0) begin
            lead_byte = shift_reg;
          end
          // The marker test uses the registers as they stand when the byte completes.
          if (lead_byte == cur_marker) begin
            frame_len      = (cur_long_len > pwfr_pkg::LEN_W'(FRAME_LIMIT)) ?
                             pwfr_pkg::LEN_W'(FRAME_LIMIT) : cur_long_len;
            marker_latched = 1'b1;
          end
          next_count           = 32'(bytes_in_frame) + 1;
          last_byte            = (next_count >= 32'(frame_len)) ||
                                 (next_count >= FRAME_LIMIT);
          produced.byte_value  = shift_reg;
          produced.byte_index  = bytes_in_frame;
          produced.frame_done  = last_byte;
          produced.marker_seen = marker_latched;
          emitted              = 1'b1;
          bytes_in_frame       = 4'(next_count);
          shift_reg            = '0;
          if (last_byte) begin
            framing = 1'b0;
          end
        end
      end
    end else if (falling && run_ticks >= cur_start_min && run_ticks <= cur_start_max) begin
      // The falling edge that closes a frame lands in the branch above, so it never
      // doubles as a start pulse.
      framing        = 1'b1;
      bit_slot       = '0;
      bytes_in_frame = '0;
      shift_reg      = '0;
    end
    if (level_change) begin
      run_ticks = '0;
    end
    prev_level = level;
  endfunction

  // Every accepted sample transaction is run through the model at the edge that accepts it.
  always @(posedge clk) begin : sample_model
    pwfr_pkg::result_t produced;
    logic              emitted;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      decode_sample(sample_ch.data.line_level, emitted, produced);
      if (emitted) begin
        pending_bytes.push_back(produced);
      end
      samples_sent++;
    end
  end

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Output side: checks each result transaction and applies random back-pressure.
  always @(posedge clk) begin : byte_check
    pwfr_pkg::result_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none actual %h", $time, result_ch.data);
          error_count++;
        end else begin
          want = pending_bytes.pop_front();
          compare_field("byte_value", 32'(want.byte_value),
                        32'(result_ch.data.byte_value));
          compare_field("byte_index", 32'(want.byte_index),
                        32'(result_ch.data.byte_index));
          compare_field("frame_done", 32'(want.frame_done),
                        32'(result_ch.data.frame_done));
          compare_field("marker_seen", 32'(want.marker_seen),
                        32'(result_ch.data.marker_seen));
          bytes_checked++;
        end
      end
      result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: a hung handshake or a missing byte ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one line sample and returns at the edge where the transaction completes.
  // Valid is left high so that back-to-back samples need no second assignment in a step.
  task automatic send_level(input logic level);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.data.line_level <= level;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic send_run(input logic level, input int unsigned count);
    repeat (count) send_level(level);
  endtask

  // A high run of the given length followed by a low run; the high length is what the
  // decoder measures, modulo 256.
  task automatic send_pulse(input int unsigned high_ticks, input int unsigned low_ticks);
    send_run(1'b1, high_ticks);
    send_run(1'b0, low_ticks);
  endtask

  // Sends the top count bits of value, first bit from the MSB, with random widths per class.
  task automatic send_bits(input logic [7:0] value, input int unsigned count);
    for (int i = 7; i > 7 - int'(count); i--) begin
      send_pulse(value[i] ? $urandom_range(one_hi, one_lo) : $urandom_range(zero_hi, 1),
                 $urandom_range(3, 1));
    end
  endtask

  task automatic send_frame(input int unsigned start_ticks, input logic [7:0] body[$]);
    send_pulse(start_ticks, $urandom_range(3, 1));
    foreach (body[i]) begin
      send_bits(body[i], 8);
    end
  endtask

  // Stops offering samples, waits for the model to see the last accepted sample, then
  // waits until every owed byte has been taken from the core.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers while the core is quiet. The decoder may well be in the
  // middle of a frame, which is deliberate: the core must use whatever is current.
  task automatic program_registers(input logic [7:0] smin, input logic [7:0] smax,
                                   input logic [7:0] thr, input logic [7:0] mark,
                                   input logic [7:0] len);
    logic [pwfr_pkg::CFG_INDEX_W-1:0] reg_sel [5];
    logic [7:0]                       reg_val [5];
    reg_sel = '{pwfr_pkg::REG_START_MIN, pwfr_pkg::REG_START_MAX,
                pwfr_pkg::REG_ONE_THRESHOLD, pwfr_pkg::REG_MARKER_BYTE,
                pwfr_pkg::REG_LONG_LENGTH};
    reg_val = '{smin, smax, thr, mark, len};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_sel[i];
      cfg_data  <= reg_val[i];
      @(posedge clk);
      case (reg_sel[i])
        pwfr_pkg::REG_START_MIN:     cur_start_min     = reg_val[i];
        pwfr_pkg::REG_START_MAX:     cur_start_max     = reg_val[i];
        pwfr_pkg::REG_ONE_THRESHOLD: cur_one_threshold = reg_val[i];
        pwfr_pkg::REG_MARKER_BYTE:   cur_marker        = reg_val[i];
        pwfr_pkg::REG_LONG_LENGTH:   cur_long_len      = reg_val[i][pwfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  // Reset values: before any marker frame the latched length is zero, so a plain frame
  // closes after its first byte; a marker frame then takes the nine-byte default length.
  task automatic test_after_reset();
    send_frame(45, '{8'h3C});
    send_frame(35, '{8'h55, 8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'h0F, 8'hF0});
  endtask

  // Start pulse window edges, rejected pulses on either side, and a run that wraps the
  // tick counter back into the window.
  task automatic test_start_window();
    program_registers(8'd4, 8'd6, 8'd2, 8'h55, 8'd2);
    zero_hi = 1;
    one_lo  = 2;
    one_hi  = 3;
    send_frame(5, '{8'h55, 8'h12});
    send_frame(3, '{8'hFF});
    send_frame(7, '{8'h00});
    // A plain frame keeps the length latched by the marker frame above.
    send_frame(4, '{8'h80, 8'h01});
    send_frame(6, '{8'h7F, 8'hFE});
    send_frame(256 + 5, '{8'h55, 8'hC3});
  endtask

  // Length register at zero, above the frame limit (also exceeding it through the
  // register's full width), and at one, kept afterwards by a plain frame.
  task automatic test_frame_length();
    logic [7:0] body[$];
    program_registers(8'd4, 8'd6, 8'd2, 8'hAA, 8'd0);
    send_frame(5, '{8'hAA});
    program_registers(8'd4, 8'd6, 8'd2, 8'hAA, 8'd31);
    body = '{8'hAA};
    repeat (FRAME_LIMIT + 1) body.push_back(8'($urandom));
    send_frame(5, body);
    program_registers(8'd4, 8'd6, 8'd2, 8'hAA, 8'd1);
    send_frame(4, '{8'hAA});
    send_frame(6, '{8'h3C});
  endtask

  // Threshold of zero makes every bit a one; threshold 255 with runs of 255 and 256
  // ticks checks the compare at the top of the range and the counter wrap. The widest
  // start window accepts even a run that wraps to zero.
  task automatic test_bit_threshold();
    int unsigned widths [8] = '{255, 256, 1, 255, 1, 256, 254, 255};
    program_registers(8'd4, 8'd6, 8'd0, 8'hFF, 8'd2);
    send_frame(5, '{8'h00, 8'h5A});
    program_registers(8'd0, 8'd255, 8'd255, 8'h91, 8'd1);
    send_pulse(256, 1);
    foreach (widths[i]) begin
      send_pulse(widths[i], 1);
    end
  endtask

  // Registers rewritten in the middle of a frame, and a frame whose last bit also has
  // the width of a start pulse: the bits that follow must not open a new frame.
  task automatic test_mid_frame_update();
    program_registers(8'd4, 8'd6, 8'd2, 8'h33, 8'd3);
    zero_hi = 1;
    one_lo  = 2;
    one_hi  = 3;
    send_pulse(5, 2);
    send_bits(8'h33, 8);
    send_bits(8'hC6, 4);
    program_registers(8'd4, 8'd6, 8'd2, 8'h44, 8'd6);
    send_bits(8'h60, 4);
    send_bits(8'hE7, 7);
    send_pulse(5, 2);
    send_bits(8'hFF, 8);
    send_frame(5, '{8'h44});
  endtask

  // Chooses a new register setting for the random part; mostly narrow, fast pulses with
  // a start window clear of the bit widths, now and then anything the registers take.
  task automatic pick_random_setting();
    logic [7:0] thr;
    logic [7:0] smin;
    logic [7:0] smax;
    logic [7:0] len;
    len = ($urandom_range(9) < 7) ? 8'($urandom_range(4, 1)) : 8'($urandom_range(31, 0));
    if ($urandom_range(9) == 0) begin
      thr      = 8'($urandom);
      smin     = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
      smax     = ($urandom_range(2) == 0) ? 8'd255 : 8'($urandom);
      zero_hi  = 3;
      one_lo   = 4;
      one_hi   = 9;
      start_lo = 32'(smin);
      start_hi = (smax >= smin) ? 32'(smax) : 32'(smin);
    end else begin
      thr      = 8'($urandom_range(6, 2));
      smin     = thr + 8'($urandom_range(8, 3));
      smax     = smin + 8'($urandom_range(4, 0));
      zero_hi  = 32'(thr) - 1;
      one_lo   = 32'(thr);
      one_hi   = 32'(thr) + 2;
      start_lo = 32'(smin);
      start_hi = 32'(smax);
      // Sometimes step one tick outside the window to hit rejected starts.
      if ($urandom_range(4) == 0) begin
        start_lo = 32'(smin) - 1;
        start_hi = 32'(smax) + 1;
      end
    end
    program_registers(smin, smax, thr, 8'($urandom), len);
  endtask

  // Mostly well-formed frames with random bytes, some opening on the marker; the rest
  // are cut-off frames, line noise and long runs, some of which wrap the tick counter.
  task automatic test_random_traffic();
    logic [7:0]  body[$];
    int unsigned first_sample;
    int unsigned frames_left;
    int unsigned kind;
    int unsigned count;
    first_sample  = samples_sent;
    frames_left   = 0;
    steady       <= 1'b1;
    while (samples_sent - first_sample < RANDOM_SAMPLES) begin
      if (steady && samples_sent - first_sample >= 600) begin
        steady <= 1'b0;
      end
      if (frames_left == 0) begin
        pick_random_setting();
        frames_left = $urandom_range(8, 2);
      end
      frames_left--;
      kind = $urandom_range(99);
      if (kind < 75) begin
        body  = {};
        count = ($urandom_range(9) == 0) ? FRAME_LIMIT : $urandom_range(4, 1);
        repeat (count) body.push_back(8'($urandom));
        if ($urandom_range(1) == 1) begin
          body[0] = cur_marker;
        end
        send_frame($urandom_range(start_hi, start_lo), body);
      end else if (kind < 87) begin
        send_pulse($urandom_range(start_hi, start_lo), $urandom_range(3, 1));
        send_bits(8'($urandom), $urandom_range(7, 1));
      end else if (kind < 97) begin
        repeat ($urandom_range(40, 5)) send_level(1'($urandom_range(1)));
      end else begin
        send_pulse($urandom_range(300, 250), $urandom_range(3, 1));
      end
    end
    steady <= 1'b0;
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    result_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_start_window();
    test_frame_length();
    test_bit_threshold();
    test_mid_frame_update();
    test_random_traffic();
    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
